// ===== src/bpda_pkg.sv =====
// ----------------------------------------------------------------------------
// bpda_pkg: shared types and constants for the button pair debouncer
// Holds the sequencer state type, the register index codes, the result item
// layout and the serial divider status shared by the modules of the block.
// ----------------------------------------------------------------------------
package bpda_pkg;

	// time base and field widths
	localparam int TIME_W   = 32;
	localparam int RATE_W   = 16;
	localparam int FACT_W   = 8;
	localparam int STEP_W   = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// serial divider: one quotient bit per cycle
	localparam int DIV_STEPS = RATE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// output queue
	localparam int OQ_DEPTH  = 4;
	localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);
	localparam int MAX_ITEMS = 3;

	// hold time thresholds for acceleration, in ms
	localparam logic [TIME_W-1:0] HOLD_1S = TIME_W'(1000);
	localparam logic [TIME_W-1:0] HOLD_2S = TIME_W'(2000);
	localparam logic [TIME_W-1:0] HOLD_3S = TIME_W'(3000);
	localparam logic [TIME_W-1:0] HOLD_4S = TIME_W'(4000);

	localparam logic signed [STEP_W-1:0] STEP_UP = 9'sd1;
	localparam logic signed [STEP_W-1:0] STEP_DN = -9'sd1;

	// register index codes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_EN  = 3'd0,
		CFG_REPORT_EN = 3'd1,
		CFG_DEBOUNCE  = 3'd2,
		CFG_DELAY     = 3'd3,
		CFG_RATE      = 3'd4,
		CFG_ACCEL_EN  = 3'd5,
		CFG_ACCEL_MAX = 3'd6
	} cfg_idx_t;

	// tick sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_DOWN,
		ST_HOLD,
		ST_FACTOR,
		ST_DIV,
		ST_REP,
		ST_FINISH
	} state_t;

	// one result item
	typedef struct packed {
		logic signed [STEP_W-1:0] step;
		logic                     last;
	} result_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic              done;
		logic [RATE_W-1:0] quot;
	} div_res_t;

endpackage

// ===== src/bpda_div.sv =====
// ----------------------------------------------------------------------------
// bpda_div: bit-serial restoring divider
// Divides the 16-bit repeat rate by the 8-bit acceleration factor, one
// quotient bit per cycle. done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module bpda_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [bpda_pkg::RATE_W-1:0]    dividend,
	input  logic [bpda_pkg::FACT_W-1:0]    divisor,
	output bpda_pkg::div_res_t             res
);
	import bpda_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FACT_W-1:0]    rem_q;
	logic [FACT_W-1:0]    dvs_q;
	logic [RATE_W-1:0]    quo_q;

	logic [FACT_W:0]      trial;
	logic                 fits;
	logic [FACT_W:0]      diff;

	// trial subtraction of one digit
	assign trial = {rem_q, quo_q[RATE_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
			end else if (busy_q) begin
				// dividend bits shift out the top, quotient bits shift in below
				rem_q <= fits ? diff[FACT_W-1:0] : trial[FACT_W-1:0];
				quo_q <= {quo_q[RATE_W-2:0], fits};
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;

endmodule

// ===== src/bpda_oq.sv =====
// ----------------------------------------------------------------------------
// bpda_oq: result item queue
// Small FIFO between the tick sequencer and the output channel, so that a
// new tick can be taken while earlier items wait to be delivered.
// ----------------------------------------------------------------------------
module bpda_oq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bpda_pkg::result_t    push_data,
	input  logic                 pop,
	output logic                 head_valid,
	output bpda_pkg::result_t    head_data,
	output logic                 room
);
	import bpda_pkg::*;

	result_t               mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q;
	logic [OQ_PTR_W-1:0]   rd_ptr_q;
	logic [OQ_CNT_W-1:0]   cnt_q;
	logic                  do_pop;

	assign do_pop = pop && (cnt_q != '0);

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + OQ_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - OQ_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head_valid = cnt_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	// space for every item one tick can make
	assign room       = cnt_q <= OQ_CNT_W'(OQ_DEPTH - MAX_ITEMS);

endmodule

// ===== src/button_pair_debounce_autorepeat_top.sv =====
// ----------------------------------------------------------------------------
// button_pair_debounce_autorepeat_top: up/down button debounce and repeat
// Takes one item per millisecond tick with the sampled active-low up and down
// levels and gives zero to three signed step items per tick.
// ----------------------------------------------------------------------------
// A tick goes from the idle state through the up, down and hold states to the
// finish state when no repeat check is due, straight to finish when the block
// is disabled, and also through the factor, divide and repeat states when a
// button has been held past the repeat delay: the repeat interval comes from a
// bit-serial divider that produces one quotient bit per cycle. Result items go
// into a 4-entry queue and are delivered while the next tick is processed; a
// tick is taken only when the queue has room for three items. Configuration
// writes are always ready and must be issued while the block is idle.
module button_pair_debounce_autorepeat_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// tick input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 up_level,
	input  logic                                 down_level,
	// result output
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [bpda_pkg::STEP_W-1:0]   step_value,
	output logic                                 last_of_tick,
	// register writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bpda_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bpda_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bpda_pkg::*;

	// configuration
	logic              block_en_q;
	logic              report_en_q;
	logic [15:0]       debounce_q;
	logic [15:0]       delay_q;
	logic [RATE_W-1:0] rate_q;
	logic              accel_en_q;
	logic [FACT_W-1:0] accel_max_q;

	// button state
	logic [TIME_W-1:0] now_q;
	logic              seen_up_q;
	logic              seen_down_q;
	logic [TIME_W-1:0] up_chg_q;
	logic [TIME_W-1:0] down_chg_q;
	logic              up_held_q;
	logic              down_held_q;
	logic [TIME_W-1:0] hold_start_q;
	logic [TIME_W-1:0] repeat_time_q;

	// tick work registers
	state_t            state_q;
	state_t            state_d;
	logic              up_q;
	logic              down_q;
	logic [TIME_W-1:0] hold_q;
	logic [FACT_W-1:0] factor_q;
	logic              pend_valid_q;
	logic signed [STEP_W-1:0] pend_step_q;

	// combinational control
	logic              in_acc;
	logic              cfg_acc;
	logic              is_dn;
	logic              btn_lvl;
	logic              btn_seen;
	logic [TIME_W-1:0] btn_chg_time;
	logic              btn_held;
	logic              btn_chg;
	logic              chg_ok;
	logic              press;
	logic              release_c;
	logic [TIME_W-1:0] hold_diff;
	logic              rep_due;
	logic [FACT_W-1:0] factor_c;
	logic              rep_ok;
	logic              emit_en;
	logic signed [STEP_W-1:0] emit_step;
	logic signed [STEP_W-1:0] rep_step;
	logic              push;
	result_t           push_data;
	logic              div_start;
	div_res_t          div_res;
	logic              oq_room;
	result_t           head;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_stall  = !((state_q == ST_IDLE) && oq_room);
	assign in_acc    = in_valid && !in_stall;

	// button under test in the up and down states
	assign is_dn        = state_q == ST_DOWN;
	assign btn_lvl      = is_dn ? down_q : up_q;
	assign btn_seen     = is_dn ? seen_down_q : seen_up_q;
	assign btn_chg_time = is_dn ? down_chg_q : up_chg_q;
	assign btn_held     = is_dn ? down_held_q : up_held_q;
	assign btn_chg      = ((state_q == ST_UP) || is_dn) && (btn_lvl != btn_seen);
	assign chg_ok       = btn_chg && ((now_q - btn_chg_time) >= {16'b0, debounce_q});
	assign press        = chg_ok && !btn_lvl && !btn_held;
	assign release_c    = chg_ok && btn_lvl && btn_held;

	// repeat gate
	assign hold_diff = now_q - hold_start_q;
	assign rep_due   = (up_held_q || down_held_q) && report_en_q &&
	                   (hold_diff >= {16'b0, delay_q});

	// acceleration factor from the registered hold time
	always_comb begin
		if (!accel_en_q) begin
			factor_c = FACT_W'(1);
		end else if (hold_q < HOLD_1S) begin
			factor_c = FACT_W'(1);
		end else if (hold_q < HOLD_2S) begin
			factor_c = FACT_W'(2);
		end else if (hold_q < HOLD_3S) begin
			factor_c = FACT_W'(3);
		end else if (hold_q < HOLD_4S) begin
			factor_c = FACT_W'(4);
		end else if (accel_max_q == '0) begin
			factor_c = FACT_W'(1);
		end else begin
			factor_c = accel_max_q;
		end
	end

	assign rep_ok   = (now_q - repeat_time_q) >= {16'b0, div_res.quot};
	assign rep_step = up_held_q ? $signed({1'b0, factor_q}) : -$signed({1'b0, factor_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = block_en_q ? ST_UP : ST_FINISH;
				end
			end
			ST_UP:     state_d = ST_DOWN;
			ST_DOWN:   state_d = ST_HOLD;
			ST_HOLD:   state_d = rep_due ? ST_FACTOR : ST_FINISH;
			ST_FACTOR: state_d = ST_DIV;
			ST_DIV: begin
				if (div_res.done) begin
					state_d = ST_REP;
				end
			end
			ST_REP:    state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: emitted steps, queue pushes, divider start
	always_comb begin
		emit_en   = 1'b0;
		emit_step = STEP_UP;
		div_start = 1'b0;
		case (state_q)
			ST_UP: begin
				emit_en   = press && report_en_q;
				emit_step = STEP_UP;
			end
			ST_DOWN: begin
				emit_en   = press && report_en_q;
				emit_step = STEP_DN;
			end
			ST_FACTOR: div_start = 1'b1;
			ST_REP: begin
				emit_en   = rep_ok;
				emit_step = rep_step;
			end
			default: ;
		endcase
		// a held step goes out once the next one, or the tick end, is known
		push           = pend_valid_q && (emit_en || (state_q == ST_FINISH));
		push_data.step = pend_step_q;
		push_data.last = state_q == ST_FINISH;
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			block_en_q    <= 1'b1;
			report_en_q   <= 1'b1;
			debounce_q    <= 16'd50;
			delay_q       <= 16'd500;
			rate_q        <= RATE_W'(100);
			accel_en_q    <= 1'b0;
			accel_max_q   <= FACT_W'(8);
			now_q         <= '0;
			seen_up_q     <= 1'b1;
			seen_down_q   <= 1'b1;
			up_chg_q      <= '0;
			down_chg_q    <= '0;
			up_held_q     <= 1'b0;
			down_held_q   <= 1'b0;
			hold_start_q  <= '0;
			repeat_time_q <= '0;
			up_q          <= 1'b1;
			down_q        <= 1'b1;
			hold_q        <= '0;
			factor_q      <= FACT_W'(1);
			pend_valid_q  <= 1'b0;
			pend_step_q   <= '0;
		end else begin
			state_q <= state_d;

			// register writes
			if (cfg_acc) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BLOCK_EN:  block_en_q  <= cfg_data[0];
					CFG_REPORT_EN: report_en_q <= cfg_data[0];
					CFG_DEBOUNCE:  debounce_q  <= cfg_data;
					CFG_DELAY:     delay_q     <= cfg_data;
					CFG_RATE:      rate_q      <= cfg_data;
					CFG_ACCEL_EN:  accel_en_q  <= cfg_data[0];
					CFG_ACCEL_MAX: accel_max_q <= cfg_data[FACT_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						up_q   <= up_level;
						down_q <= down_level;
					end
				end
				ST_UP: begin
					if (btn_chg) begin
						seen_up_q <= up_q;
					end
					if (chg_ok) begin
						up_chg_q <= now_q;
					end
					if (press) begin
						up_held_q     <= 1'b1;
						hold_start_q  <= now_q;
						repeat_time_q <= now_q;
					end else if (release_c) begin
						up_held_q    <= 1'b0;
						hold_start_q <= '0;
					end
				end
				ST_DOWN: begin
					if (btn_chg) begin
						seen_down_q <= down_q;
					end
					if (chg_ok) begin
						down_chg_q <= now_q;
					end
					if (press) begin
						down_held_q   <= 1'b1;
						hold_start_q  <= now_q;
						repeat_time_q <= now_q;
					end else if (release_c) begin
						down_held_q  <= 1'b0;
						hold_start_q <= '0;
					end
				end
				ST_HOLD:   hold_q   <= hold_diff;
				ST_FACTOR: factor_q <= factor_c;
				ST_REP: begin
					if (rep_ok) begin
						repeat_time_q <= now_q;
					end
				end
				ST_FINISH: now_q <= now_q + TIME_W'(1);
				default: ;
			endcase

			// one-deep hold of the newest step of the tick
			if (emit_en) begin
				pend_valid_q <= 1'b1;
				pend_step_q  <= emit_step;
			end else if (state_q == ST_FINISH) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	bpda_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rate_q),
		.divisor  (factor_c),
		.res      (div_res)
	);

	bpda_oq u_oq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (!out_stall),
		.head_valid (out_valid),
		.head_data  (head),
		.room       (oq_room)
	);

	assign step_value   = head.step;
	assign last_of_tick = head.last;

endmodule
